// ===== rtl/rms_pkg.sv =====
// Shared types, codes and helper functions for the range median smoother and
// stuck-sensor watchdog. No dependencies; every other file imports this package.

package rms_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_IDLE_RANGE    = 3'd0;
   localparam logic [2:0] CSR_PRESS_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_STUCK_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_READ_INTERVAL = 3'd3;
   localparam logic [2:0] CSR_RESET_DELAY   = 3'd4;
   localparam logic [2:0] CSR_CALIBRATING   = 3'd5;

   localparam logic [15:0] IDLE_RANGE_RESET    = 16'd0;
   localparam logic [15:0] PRESS_LIMIT_RESET   = 16'd0;
   localparam logic [7:0]  STUCK_LIMIT_RESET   = 8'd10;
   localparam logic [15:0] READ_INTERVAL_RESET = 16'd10;
   localparam logic [15:0] RESET_DELAY_RESET   = 16'd100;

   // Function codes carried on the request side.
   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_UPDATE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   // Sensor commands reported with each result.
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_STOP    = 2'd2,
      CMD_START   = 2'd3
   } cmd_type;

   // Operating mode, one-hot.
   typedef enum logic [5:0] {
      MODE_UNINIT = 6'b000001,
      MODE_OPER   = 6'b000010,
      MODE_RST1   = 6'b000100,
      MODE_RST2   = 6'b001000,
      MODE_RST3   = 6'b010000,
      MODE_ERROR  = 6'b100000
   } mode_type;

   // Mode numbers as reported on the result channel.
   localparam logic [2:0] MODE_CODE_UNINIT = 3'd0;
   localparam logic [2:0] MODE_CODE_OPER   = 3'd1;
   localparam logic [2:0] MODE_CODE_RST1   = 3'd2;
   localparam logic [2:0] MODE_CODE_RST2   = 3'd3;
   localparam logic [2:0] MODE_CODE_RST3   = 3'd4;
   localparam logic [2:0] MODE_CODE_ERROR  = 3'd5;

   typedef struct packed {
      func_type    func;
      logic [31:0] now_ms;
      logic        sample_ready;
      logic [7:0]  raw_range;
      logic        init_ok;
   } req_item_type;

   typedef struct packed {
      logic [15:0] range_value;
      logic        pressed;
      logic [2:0]  mode;
      cmd_type     sensor_cmd;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] idle_range;
      logic [15:0] press_limit;
      logic [7:0]  stuck_limit;
      logic [15:0] read_interval;
      logic [15:0] reset_delay;
      logic        calibrating;
   } cfg_type;

   // Stuck count increment that holds at full scale.
   function automatic logic [7:0] sat_inc(input logic [7:0] count);
      logic [7:0] res;
      res = (count == 8'hFF) ? count : count + 8'd1;
      return res;
   endfunction

   function automatic logic [2:0] mode_code(input mode_type mode);
      logic [2:0] res;
      unique case (mode)
         MODE_UNINIT: res = MODE_CODE_UNINIT;
         MODE_OPER:   res = MODE_CODE_OPER;
         MODE_RST1:   res = MODE_CODE_RST1;
         MODE_RST2:   res = MODE_CODE_RST2;
         MODE_RST3:   res = MODE_CODE_RST3;
         MODE_ERROR:  res = MODE_CODE_ERROR;
         default:     res = MODE_CODE_UNINIT;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/rms_median.sv =====
// Three-sample median window: holds the last three raw samples and gives the
// median including the incoming sample. Depends on rms_pkg.

module rms_median import rms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] sample,
   output logic [7:0] median
);

   logic [7:0] window_ff [3];
   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic [1:0] slot;
   logic [7:0] win_a;
   logic [7:0] win_b;
   logic [7:0] win_c;
   logic [7:0] lo_ab;
   logic [7:0] hi_ab;
   logic [7:0] mid_hi;

   assign slot    = (pos_ff == 2'd3) ? 2'd0 : pos_ff;
   assign pos_in  = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
   assign fill_in = (fill_ff == 2'd3) ? fill_ff : fill_ff + 2'd1;

   // The window as it stands once the new sample is written in.
   assign win_a = (slot == 2'd0) ? sample : window_ff[0];
   assign win_b = (slot == 2'd1) ? sample : window_ff[1];
   assign win_c = (slot == 2'd2) ? sample : window_ff[2];

   // Median of three as max(min(a, b), min(max(a, b), c)).
   assign lo_ab  = (win_a < win_b) ? win_a : win_b;
   assign hi_ab  = (win_a < win_b) ? win_b : win_a;
   assign mid_hi = (hi_ab < win_c) ? hi_ab : win_c;

   // Until the window is full the sample passes straight through.
   assign median = (fill_in != 2'd3) ? sample : ((lo_ab < mid_hi) ? mid_hi : lo_ab);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         fill_ff <= 2'd0;
      end else if (load) begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         window_ff[slot] <= sample;
      end
   end

endmodule

// ===== rtl/rms_core.sv =====
// Per-item state update: mode sequencing, stuck watchdog and 8.8 averaging.
// Depends on rms_pkg and rms_median.

module rms_core import rms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   mode_type    mode_ff;
   mode_type    mode_in;
   logic [15:0] smooth_ff;
   logic [15:0] smooth_in;
   logic        first_ff;
   logic        first_in;
   logic [7:0]  count_ff;
   logic [7:0]  count_in;
   logic [31:0] last_read_ff;
   logic [31:0] last_read_in;
   logic [31:0] action_ff;
   logic [31:0] action_in;
   cmd_type     cmd;
   logic        med_load;
   logic [7:0]  med_value;
   logic [15:0] new_value;
   logic [16:0] sum;
   logic [15:0] average;
   logic        read_due;
   logic        step_due;
   logic [7:0]  count_miss;
   logic [7:0]  count_hit;

   rms_median u_median (
      .clock  (clock),
      .reset  (reset),
      .load   (med_load),
      .sample (item.raw_range),
      .median (med_value)
   );

   assign new_value  = {med_value, 8'h00};
   assign sum        = {1'b0, smooth_ff} + {1'b0, new_value};
   assign average    = sum[16:1];
   assign read_due   = (item.now_ms - last_read_ff) > {16'd0, cfg.read_interval};
   assign step_due   = (item.now_ms - action_ff) > {16'd0, cfg.reset_delay};
   assign count_miss = sat_inc(count_ff);
   assign count_hit  = (smooth_ff == new_value) ? sat_inc(count_ff) : 8'd0;

   assign med_load = step && (item.func == FUNC_UPDATE) && (mode_ff == MODE_OPER)
                     && read_due && item.sample_ready;

   always_comb begin
      mode_in      = mode_ff;
      smooth_in    = smooth_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      last_read_in = last_read_ff;
      action_in    = action_ff;
      cmd          = CMD_NONE;
      unique case (item.func)
         FUNC_START: begin
            if (item.init_ok) begin
               mode_in = MODE_OPER;
               cmd     = CMD_START;
            end
         end
         FUNC_UPDATE: begin
            unique case (mode_ff)
               MODE_UNINIT: begin
                  smooth_in = cfg.idle_range;
               end
               MODE_OPER: begin
                  if (read_due && !item.sample_ready) begin
                     count_in = count_miss;
                     if (count_miss >= cfg.stuck_limit) begin
                        cmd = CMD_RESTART;
                        if (!item.init_ok) begin
                           mode_in = MODE_ERROR;
                        end else begin
                           mode_in   = MODE_RST1;
                           action_in = item.now_ms;
                           count_in  = 8'd0;
                        end
                     end
                  end else if (read_due) begin
                     last_read_in = item.now_ms;
                     if (!first_ff) begin
                        smooth_in = new_value;
                        first_in  = 1'b1;
                     end else begin
                        count_in  = count_hit;
                        smooth_in = average;
                        if (count_hit >= cfg.stuck_limit) begin
                           cmd = CMD_RESTART;
                           if (!item.init_ok) begin
                              // Sensor would not come back: keep the old average.
                              mode_in   = MODE_ERROR;
                              smooth_in = smooth_ff;
                           end else begin
                              mode_in   = MODE_RST1;
                              action_in = item.now_ms;
                              count_in  = 8'd0;
                           end
                        end
                     end
                  end
               end
               MODE_RST1: begin
                  if (step_due) begin
                     cmd       = CMD_STOP;
                     mode_in   = MODE_RST2;
                     action_in = item.now_ms;
                  end
               end
               MODE_RST2: begin
                  if (step_due) begin
                     cmd       = CMD_START;
                     mode_in   = MODE_RST3;
                     action_in = item.now_ms;
                  end
               end
               MODE_RST3: begin
                  if (step_due) begin
                     mode_in   = MODE_OPER;
                     action_in = item.now_ms;
                  end
               end
               default: begin
                  // Error mode: updates are ignored.
               end
            endcase
         end
         FUNC_READ: begin
            if (!cfg.calibrating && !first_ff) begin
               smooth_in = cfg.idle_range;
               first_in  = 1'b1;
            end
         end
         default: begin
            // Unused function code: report the current state only.
         end
      endcase
   end

   assign result.range_value = smooth_in;
   assign result.pressed     = (smooth_in <= cfg.press_limit);
   assign result.mode        = mode_code(mode_in);
   assign result.sensor_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNINIT;
         smooth_ff    <= 16'd0;
         first_ff     <= 1'b0;
         count_ff     <= 8'd0;
         last_read_ff <= 32'd0;
         action_ff    <= 32'd0;
      end else if (step) begin
         mode_ff      <= mode_in;
         smooth_ff    <= smooth_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         last_read_ff <= last_read_in;
         action_ff    <= action_in;
      end
   end

endmodule

// ===== rtl/range_median_smooth_stuck_watchdog.sv =====
// Top level of the range median smoother with stuck-sensor watchdog: request
// register, configuration registers and result register. Depends on rms_pkg, rms_core.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_tvalid/req_tready  tuser func, tdata timestamp and sample
//   rsp_      out         rsp_tvalid/rsp_tready  tdata range, pressed, mode, command
//   csr_      in          csr_we (no wait)       csr_index, csr_wdata
//
// Each request transfer is captured in an input register and, in the cycle it
// moves on, passes through one level of logic (median, average, watchdog) into
// the result register. A new one is accepted every cycle unless the result side
// stalls; then one item waits in the result register and one more in the input
// register. Reset is synchronous and returns every register, mode and count but
// the item registers and the median window to its documented value.

module range_median_smooth_stuck_watchdog import rms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [47:0] req_tdata,   // [31:0] now_ms, [32] sample_ready,
                                    // [40:33] raw_range, [41] init_ok, rest zero
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] range_value, [16] pressed,
                                    // [19:17] mode, [21:20] sensor_cmd, rest zero
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   req_item_type req_item;
   logic         advance;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   cfg_type      cfg_ff;

   // Unpack the request transfer into its fields.
   assign req_item.func         = func_type'(req_tuser);
   assign req_item.now_ms       = req_tdata[31:0];
   assign req_item.sample_ready = req_tdata[32];
   assign req_item.raw_range    = req_tdata[40:33];
   assign req_item.init_ok      = req_tdata[41];

   // The held item moves into the result register whenever that register is
   // empty or is being emptied in the same cycle.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_item_ff <= req_item;
      end
   end

   rms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_item_ff.sensor_cmd, out_item_ff.mode,
                        out_item_ff.pressed, out_item_ff.range_value};

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_range    <= IDLE_RANGE_RESET;
         cfg_ff.press_limit   <= PRESS_LIMIT_RESET;
         cfg_ff.stuck_limit   <= STUCK_LIMIT_RESET;
         cfg_ff.read_interval <= READ_INTERVAL_RESET;
         cfg_ff.reset_delay   <= RESET_DELAY_RESET;
         cfg_ff.calibrating   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_RANGE:    cfg_ff.idle_range    <= csr_wdata;
            CSR_PRESS_LIMIT:   cfg_ff.press_limit   <= csr_wdata;
            CSR_STUCK_LIMIT:   cfg_ff.stuck_limit   <= csr_wdata[7:0];
            CSR_READ_INTERVAL: cfg_ff.read_interval <= csr_wdata;
            CSR_RESET_DELAY:   cfg_ff.reset_delay   <= csr_wdata;
            CSR_CALIBRATING:   cfg_ff.calibrating   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/sv/range_smooth_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the range median smoother: follows the request, result and register ports,
// predicts each report from its own model of the filter and watchdog, and counts errors.
// Depends on rms_pkg for the item layouts, codes and register indexes.

module range_smooth_checker import rms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic [47:0] req_tdata,   // [31:0] now_ms, [32] sample_ready, [40:33] raw_range,
                                    // [41] init_ok
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [15:0] range_value, [16] pressed, [19:17] mode,
                                    // [21:20] sensor_cmd
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          pending,
   output int          checked
);

   cfg_type      cfg;
   logic [2:0]   mode_now;
   logic [15:0]  smooth_avg;
   logic         sample_seen;
   logic [7:0]   stuck_cnt;
   logic [31:0]  last_sample_ms;
   logic [31:0]  step_ms;
   logic [7:0]   win [0:2];
   logic [1:0]   win_pos;
   logic [1:0]   win_fill;
   rsp_item_type range_reports_due [$];
   int           bad_count;
   int           result_count;

   // Restart request once the stuck count has reached its limit.
   task automatic watchdog_trip(input logic [31:0] stamp, input logic ok,
                                inout cmd_type cmd, output logic halted);
      halted = 1'b0;
      if (stuck_cnt >= cfg.stuck_limit) begin
         cmd = CMD_RESTART;
         if (!ok) begin
            mode_now = MODE_CODE_ERROR;
            halted   = 1'b1;
         end else begin
            mode_now  = MODE_CODE_RST1;
            step_ms   = stamp;
            stuck_cnt = 8'd0;
         end
      end
   endtask

   task automatic next_range_report(input req_item_type it, output rsp_item_type rep);
      cmd_type     cmd;
      logic [31:0] gap;
      logic [7:0]  a, b, c, t, med;
      logic [15:0] nv;
      logic [16:0] sum;
      logic        halted;
      cmd = CMD_NONE;
      case (it.func)
         FUNC_START: begin
            if (it.init_ok) begin
               mode_now = MODE_CODE_OPER;
               cmd      = CMD_START;
            end
         end
         FUNC_UPDATE: begin
            case (mode_now)
               MODE_CODE_UNINIT: smooth_avg = cfg.idle_range;
               MODE_CODE_OPER: begin
                  gap = it.now_ms - last_sample_ms;
                  if (gap > {16'd0, cfg.read_interval}) begin
                     if (!it.sample_ready) begin
                        if (stuck_cnt != 8'hFF) stuck_cnt = stuck_cnt + 8'd1;
                        watchdog_trip(it.now_ms, it.init_ok, cmd, halted);
                     end else begin
                        last_sample_ms = it.now_ms;
                        // Median of the last three raw samples, pass-through until full.
                        win[win_pos] = it.raw_range;
                        win_pos = (win_pos == 2'd2) ? 2'd0 : win_pos + 2'd1;
                        if (win_fill < 2'd3) win_fill++;
                        if (win_fill < 2'd3) begin
                           med = it.raw_range;
                        end else begin
                           a = win[0];
                           b = win[1];
                           c = win[2];
                           if (a > b) begin t = a; a = b; b = t; end
                           if (b > c) begin t = b; b = c; c = t; end
                           if (a > b) begin t = a; a = b; b = t; end
                           med = b;
                        end
                        nv = {med, 8'h00};
                        if (!sample_seen) begin
                           smooth_avg  = nv;
                           sample_seen = 1'b1;
                        end else begin
                           if (smooth_avg == nv) begin
                              if (stuck_cnt != 8'hFF) stuck_cnt = stuck_cnt + 8'd1;
                           end else begin
                              stuck_cnt = 8'd0;
                           end
                           watchdog_trip(it.now_ms, it.init_ok, cmd, halted);
                           if (!halted) begin
                              sum = {1'b0, smooth_avg} + {1'b0, nv};
                              smooth_avg = sum[16:1];
                           end
                        end
                     end
                  end
               end
               MODE_CODE_RST1: begin
                  gap = it.now_ms - step_ms;
                  if (gap > {16'd0, cfg.reset_delay}) begin
                     cmd      = CMD_STOP;
                     mode_now = MODE_CODE_RST2;
                     step_ms  = it.now_ms;
                  end
               end
               MODE_CODE_RST2: begin
                  gap = it.now_ms - step_ms;
                  if (gap > {16'd0, cfg.reset_delay}) begin
                     cmd      = CMD_START;
                     mode_now = MODE_CODE_RST3;
                     step_ms  = it.now_ms;
                  end
               end
               MODE_CODE_RST3: begin
                  gap = it.now_ms - step_ms;
                  if (gap > {16'd0, cfg.reset_delay}) begin
                     mode_now = MODE_CODE_OPER;
                     step_ms  = it.now_ms;
                  end
               end
               default: ;
            endcase
         end
         FUNC_READ: begin
            if (!cfg.calibrating && !sample_seen) begin
               smooth_avg  = cfg.idle_range;
               sample_seen = 1'b1;
            end
         end
         default: ;
      endcase
      rep.range_value = smooth_avg;
      rep.pressed     = (smooth_avg <= cfg.press_limit);
      rep.mode        = mode_now;
      rep.sensor_cmd  = cmd;
   endtask

   always @(posedge clock) begin
      req_item_type it;
      rsp_item_type got, want;
      if (reset) begin
         cfg            = '{IDLE_RANGE_RESET, PRESS_LIMIT_RESET, STUCK_LIMIT_RESET,
                            READ_INTERVAL_RESET, RESET_DELAY_RESET, 1'b0};
         mode_now       = MODE_CODE_UNINIT;
         smooth_avg     = 16'd0;
         sample_seen    = 1'b0;
         stuck_cnt      = 8'd0;
         last_sample_ms = 32'd0;
         step_ms        = 32'd0;
         win            = '{8'd0, 8'd0, 8'd0};
         win_pos        = 2'd0;
         win_fill       = 2'd0;
         range_reports_due.delete();
         bad_count      = 0;
         result_count   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IDLE_RANGE:    cfg.idle_range    = csr_wdata;
               CSR_PRESS_LIMIT:   cfg.press_limit   = csr_wdata;
               CSR_STUCK_LIMIT:   cfg.stuck_limit   = csr_wdata[7:0];
               CSR_READ_INTERVAL: cfg.read_interval = csr_wdata;
               CSR_RESET_DELAY:   cfg.reset_delay   = csr_wdata;
               CSR_CALIBRATING:   cfg.calibrating   = csr_wdata[0];
               default: ;
            endcase
         end
         // Results are taken before requests so that a result can never be matched
         // against an item accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got.range_value = rsp_tdata[15:0];
            got.pressed     = rsp_tdata[16];
            got.mode        = rsp_tdata[19:17];
            got.sensor_cmd  = cmd_type'(rsp_tdata[21:20]);
            if (range_reports_due.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("%0t: result %0d arrived with nothing expected: range %h mode %0d",
                           $time, result_count, got.range_value, got.mode);
            end else begin
               want = range_reports_due.pop_front();
               if (got.range_value !== want.range_value || got.pressed !== want.pressed ||
                   got.mode !== want.mode || got.sensor_cmd !== want.sensor_cmd) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"%0t: result %0d wrong: expected range %h pressed %b mode %0d ",
                               "cmd %0d, got range %h pressed %b mode %0d cmd %0d"},
                              $time, result_count, want.range_value, want.pressed,
                              want.mode, want.sensor_cmd, got.range_value, got.pressed,
                              got.mode, got.sensor_cmd);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            it.func         = func_type'(req_tuser);
            it.now_ms       = req_tdata[31:0];
            it.sample_ready = req_tdata[32];
            it.raw_range    = req_tdata[40:33];
            it.init_ok      = req_tdata[41];
            next_range_report(it, want);
            range_reports_due.push_back(want);
         end
      end
      pending    <= range_reports_due.size();
      mismatches <= bad_count;
      checked    <= result_count;
   end

endmodule

// ===== tb/sv/tb_range_median_smooth_stuck_watchdog.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the range median smoother with stuck-sensor watchdog: clock,
// reset, register settings, request stimulus and result back-pressure, and the verdict.
// Depends on rms_pkg, the block itself and range_smooth_checker.

module tb_range_median_smooth_stuck_watchdog;
   import rms_pkg::*;

   // Function code that the block has no use for; it must leave all state alone.
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   int          mismatches;
   int          pending;
   int          checked;
   int          requests_sent  = 0;
   int          settings_used  = 0;

   // Running millisecond clock that the update items advance, and the register values in
   // force, which shape the time steps so that reads and reset steps fall due or just miss.
   logic [31:0] clock_ms    = 32'd0;
   int          stuck_lim   = 10;
   int          read_gap_ms = 10;
   int          step_gap_ms = 100;
   logic        req_steady  = 1'b0;
   logic        rsp_steady  = 1'b0;

   range_median_smooth_stuck_watchdog dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   range_smooth_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. The slowest legal run needs well under a tenth of this.
   initial begin
      #2_000_000;
      $display("Timed out with %0d results still outstanding", pending);
      $display("Mismatches found");
      $finish;
   end

   // Result side: before each transfer a stall of random length is drawn, except in
   // stretches where the receiver takes every result at once.
   initial begin
      int gap;
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
         gap = rsp_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // One request transfer, with a random idle gap in front of it. The task returns at the
   // edge of the transfer with tvalid still high, so that a following item can go out with
   // no gap.
   task automatic send_req(input logic [1:0] func, input logic [31:0] stamp,
                           input logic ready, input logic [7:0] raw, input logic ok);
      int gap;
      if ($urandom_range(0, 15) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'd0, ok, raw, ready, stamp};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // An update item, dt milliseconds after the previous one.
   task automatic tick(input int unsigned dt, input logic ready, input logic [7:0] raw,
                       input logic ok);
      clock_ms = clock_ms + dt;
      send_req(FUNC_UPDATE, clock_ms, ready, raw, ok);
   endtask

   // Stops the request side and waits until every expected result has been checked.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [15:0] idle, input logic [15:0] press,
                           input logic [7:0] stuck, input logic [15:0] rgap,
                           input logic [15:0] sgap, input logic cal);
      write_reg(CSR_IDLE_RANGE, idle);
      write_reg(CSR_PRESS_LIMIT, press);
      write_reg(CSR_STUCK_LIMIT, {8'd0, stuck});
      write_reg(CSR_READ_INTERVAL, rgap);
      write_reg(CSR_RESET_DELAY, sgap);
      write_reg(CSR_CALIBRATING, {15'd0, cal});
      csr_we <= 1'b0;
      stuck_lim   = int'(stuck);
      read_gap_ms = int'(rgap);
      step_gap_ms = int'(sgap);
      settings_used++;
   endtask

   // Mixed traffic. Most of it is runs of due updates that either miss their sample or
   // repeat one level, enough to reach a stuck limit of up to twelve, followed by updates
   // spaced around the reset delay so that the restart walk gets through. Plain updates,
   // starts, reads and some noise with arbitrary timestamps and codes fill the rest.
   task automatic run_mixed(input int count);
      int         sent;
      int         pick;
      int         burst;
      logic       dry;
      logic [7:0] level;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_req(FUNC_START, clock_ms, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
            sent++;
         end else if (pick < 16) begin
            send_req(FUNC_READ, clock_ms, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 21) begin
            send_req(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 50) begin
            burst = ((stuck_lim > 12) ? 12 : stuck_lim) + 2;
            dry   = 1'($urandom_range(0, 1));
            // Low levels make the average settle onto the sample from above, so that
            // unchanged samples actually occur.
            level = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                         : 8'($urandom_range(0, 255));
            for (int k = 0; k < burst; k++)
               tick(read_gap_ms + 1 + $urandom_range(0, 2), !dry, level,
                    $urandom_range(0, 7) != 0);
            for (int k = 0; k < 4; k++)
               tick(step_gap_ms + $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
            sent += burst + 4;
         end else begin
            tick($urandom_range(0, 2 * read_gap_ms + 2), $urandom_range(0, 4) != 0,
                 8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Calibration is on at first, so the opening read leaves the average
      // alone and the first valid sample still loads it directly. Timestamps are chosen so
      // that each wait lands exactly on its limit and one past it.
      set_regs(16'h3A80, 16'h3A80, 8'd2, 16'd10, 16'd100, 1'b1);
      send_req(FUNC_READ,   32'd0,   1'b0, 8'h00, 1'b0);
      send_req(FUNC_UPDATE, 32'd3,   1'b1, 8'hFF, 1'b1);   // uninitialised: idle load
      send_req(FUNC_SPARE,  32'd4,   1'b1, 8'h55, 1'b1);
      send_req(FUNC_START,  32'd5,   1'b0, 8'h00, 1'b0);   // failed start
      send_req(FUNC_START,  32'd6,   1'b0, 8'h00, 1'b1);
      send_req(FUNC_UPDATE, 32'd10,  1'b1, 8'hFF, 1'b1);   // interval not yet exceeded
      send_req(FUNC_UPDATE, 32'd11,  1'b1, 8'hFF, 1'b1);   // first sample
      send_req(FUNC_UPDATE, 32'd22,  1'b1, 8'hFF, 1'b1);   // unchanged sample
      send_req(FUNC_UPDATE, 32'd33,  1'b1, 8'h00, 1'b1);   // median hides the zero: restart
      send_req(FUNC_UPDATE, 32'd133, 1'b0, 8'h00, 1'b1);
      send_req(FUNC_UPDATE, 32'd134, 1'b0, 8'h00, 1'b1);   // stop
      send_req(FUNC_UPDATE, 32'd235, 1'b0, 8'h00, 1'b1);   // start
      send_req(FUNC_UPDATE, 32'd336, 1'b0, 8'h00, 1'b1);   // back to operating
      send_req(FUNC_UPDATE, 32'd347, 1'b0, 8'h00, 1'b1);   // missing sample
      send_req(FUNC_UPDATE, 32'd358, 1'b0, 8'h00, 1'b0);   // restart fails: error
      send_req(FUNC_UPDATE, 32'd500, 1'b1, 8'h80, 1'b1);   // ignored in error
      send_req(FUNC_READ,   32'd501, 1'b1, 8'h80, 1'b1);
      send_req(FUNC_START,  32'd502, 1'b0, 8'h00, 1'b1);
      send_req(FUNC_UPDATE, 32'hFFFF_FFF0, 1'b1, 8'h80, 1'b1);
      send_req(FUNC_UPDATE, 32'h0000_0005, 1'b1, 8'h7F, 1'b1);   // timestamp wrapped
      send_req(FUNC_UPDATE, 32'h0000_000F, 1'b1, 8'h00, 1'b1);
      send_req(FUNC_UPDATE, 32'h0000_0010, 1'b1, 8'h00, 1'b0);
      clock_ms = 32'h0000_0010;
      settle();

      // Top of the idle and press ranges, with no wait at all between reads or reset steps.
      set_regs(16'hFFFF, 16'hFFFF, 8'd10, 16'd0, 16'd0, 1'b0);
      clock_ms = $urandom;
      run_mixed(45);
      settle();

      // Largest stuck limit: a long run of missing samples drives the count to full scale,
      // fails the restart, and after a start the saturated count trips again at once.
      set_regs(16'h0000, 16'h0000, 8'd255, 16'd3, 16'd1, 1'b1);
      send_req(FUNC_START, clock_ms, 1'b0, 8'h00, 1'b1);
      for (int k = 0; k < 260; k++)
         tick(read_gap_ms + 1 + $urandom_range(0, 2), 1'b0, 8'($urandom_range(0, 255)),
              1'b0);
      send_req(FUNC_START, clock_ms, 1'b0, 8'h00, 1'b1);
      for (int k = 0; k < 3; k++)
         tick(read_gap_ms + 1, 1'b0, 8'($urandom_range(0, 255)), 1'b0);
      send_req(FUNC_START, clock_ms, 1'b0, 8'h00, 1'b1);
      tick(read_gap_ms + 1, 1'b0, 8'($urandom_range(0, 255)), 1'b1);
      run_mixed(20);
      settle();

      // Longest waits, a stuck limit of one, clock close to wrapping round.
      set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd1,
               16'hFFFF, 16'hFFFF, 1'b0);
      clock_ms = 32'hFFF0_0000 + $urandom_range(0, 65535);
      run_mixed(45);
      settle();

      // A stuck limit of zero restarts on every due update but the one that loads the first sample.
      set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd0,
               16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
               1'($urandom_range(0, 1)));
      run_mixed(45);
      settle();

      set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(2, 12)), 16'($urandom_range(0, 40)),
               16'($urandom_range(0, 300)), 1'($urandom_range(0, 1)));
      run_mixed(45);
      settle();

      $display("Sent %0d request transfers and checked %0d results under %0d register settings,",
               requests_sent, checked, settings_used);
      $display("including the restart walk, failed restarts and wrap-round timestamps.");
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
